// ----- src/cartridge_bus_address_decoder_macros.svh -----
// Assertion macros shared by the cartridge bus address decoder RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef CARTRIDGE_BUS_ADDRESS_DECODER_MACROS_SVH
`define CARTRIDGE_BUS_ADDRESS_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CBAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CBAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cbad_pkg.sv -----
// Shared types and constants for the cartridge bus address decoder.
// No dependencies; used by cbad_decode and the top level.
package cbad_pkg;

  // Region codes of a result beat
  localparam logic [2:0] REGION_ROM   = 3'd0;
  localparam logic [2:0] REGION_SAVE  = 3'd1;
  localparam logic [2:0] REGION_WORK  = 3'd2;
  localparam logic [2:0] REGION_IO    = 3'd3;
  localparam logic [2:0] REGION_FAULT = 3'd4;

  // Mapping modes
  localparam logic [1:0] MODE_LOROM   = 2'd0;
  localparam logic [1:0] MODE_HIROM   = 2'd1;
  localparam logic [1:0] MODE_EXHIROM = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROM_MODE   = 2'd0;
  localparam logic [1:0] CFG_ROM_BYTES  = 2'd1;
  localparam logic [1:0] CFG_SRAM_LOG2  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [1:0]  ROM_MODE_RST  = MODE_LOROM;
  localparam logic [23:0] ROM_BYTES_RST = 24'h40_0000;
  localparam logic [4:0]  SRAM_LOG2_RST = 5'd13;

  localparam int CFG_DATA_W = 24;
  localparam int INDEX_W    = 23;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  bank;
    logic [15:0] offset;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         region;
    logic [INDEX_W-1:0] index;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  rom_mode;
    logic [23:0] rom_bytes;
    logic [4:0]  sram_log2;
  } cfg_t;

endpackage

// ----- src/cartridge_bus_address_decoder.sv -----
// An accepted input beat passes through the input register, the decode and then the
// result register on out_*. Throughput: one access per clock while out_stall is low; the decode
// between the input and result registers is a single pass of compare and select logic.
// Reset (rst_n, synchronous): pipeline empty, rom_mode low-ROM, rom_bytes 4 MiB,
// save RAM size 8 KiB. Depends on cbad_pkg, cbad_decode and the macros header.
`include "cartridge_bus_address_decoder_macros.svh"

module cartridge_bus_address_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cbad_pkg::in_beat_t         in_beat,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cbad_pkg::out_beat_t        out_beat,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [cbad_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cbad_pkg::*;

  cfg_t      cfg_r;
  logic      s1_vld_r;
  in_beat_t  s1_beat_r;
  logic      out_vld_r;
  out_beat_t out_beat_r;
  out_beat_t dec_beat;
  logic      out_load;
  logic      in_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_mode  <= ROM_MODE_RST;
      cfg_r.rom_bytes <= ROM_BYTES_RST;
      cfg_r.sram_log2 <= SRAM_LOG2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_MODE:  cfg_r.rom_mode  <= cfg_wdata[1:0];
        CFG_ROM_BYTES: cfg_r.rom_bytes <= cfg_wdata[23:0];
        CFG_SRAM_LOG2: cfg_r.sram_log2 <= cfg_wdata[4:0];
        default:       ;
      endcase
    end
  end

  // Pipeline handshake: result register frees when empty or taken
  assign out_load = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (out_load) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_beat_r <= in_beat;
    end
  end

  cbad_decode u_decode (
    .req (s1_beat_r),
    .cfg (cfg_r),
    .rsp (dec_beat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_beat_r <= dec_beat;
    end
  end

  assign out_valid = out_vld_r;
  assign out_beat  = out_beat_r;

  // Checks
  `CBAD_ASSERT_IMP(a_fault_idx_zero, out_vld_r && out_beat_r.region == REGION_FAULT, out_beat_r.index == '0, "fault beat with nonzero index")
  `CBAD_ASSERT_IMP(a_write_no_cart, s1_vld_r && s1_beat_r.req_type, dec_beat.region != REGION_ROM && dec_beat.region != REGION_SAVE, "write decoded to ROM or save RAM")
  `CBAD_ASSERT_NXT(a_hold_pending, s1_vld_r && !out_load, s1_vld_r, "pending access dropped")
  `CBAD_ASSERT_IMP(a_region_legal, out_vld_r, out_beat_r.region <= REGION_FAULT, "region code out of range")

endmodule

// ----- src/cbad_decode.sv -----
// Combinational address decode of one bus access into region and index.
// Depends on cbad_pkg.
module cbad_decode (
  input  cbad_pkg::in_beat_t  req,
  input  cbad_pkg::cfg_t      cfg,
  output cbad_pkg::out_beat_t rsp
);
  import cbad_pkg::*;

  logic        upper;
  logic        sys_bank;
  logic        wram_bank;
  logic        lo_rom_hit;
  logic        lo_save_hit;
  logic        hi_rom_hit;
  logic        rom_hit;
  logic [22:0] rom_idx;
  logic [15:0] sram_mask;

  // Address classification
  assign upper     = req.offset[15];
  assign sys_bank  = ~req.bank[6];
  assign wram_bank = (req.bank[7:1] == 7'h3F);

  // Cartridge areas per mode; writes never reach ROM or save RAM
  assign lo_rom_hit  = ~req.req_type && (cfg.rom_mode == MODE_LOROM) && ~wram_bank && upper;
  assign lo_save_hit = ~req.req_type && (cfg.rom_mode == MODE_LOROM) && ~wram_bank
                       && (req.bank[7:4] == 4'h7) && ~upper;
  assign hi_rom_hit  = ~req.req_type
                       && (cfg.rom_mode == MODE_HIROM || cfg.rom_mode == MODE_EXHIROM)
                       && ((sys_bank && upper) || (req.bank[7:6] == 2'b01 && ~wram_bank)
                           || (req.bank[7:6] == 2'b11));
  assign rom_hit = lo_rom_hit || hi_rom_hit;

  // ROM index: 32 KiB pages in low-ROM, 64 KiB banks otherwise
  always_comb begin
    if (lo_rom_hit) begin
      rom_idx = {1'b0, req.bank[6:0], req.offset[14:0]};
    end else begin
      rom_idx = {(cfg.rom_mode == MODE_EXHIROM) && ~req.bank[7], req.bank[5:0], req.offset};
    end
  end

  // Save RAM size is a power of two; 16 and up masks nothing
  assign sram_mask = cfg.sram_log2[4] ? 16'hFFFF : ~(16'hFFFF << cfg.sram_log2[3:0]);

  // Region select
  always_comb begin
    rsp.region = REGION_FAULT;
    rsp.index  = '0;
    if (rom_hit) begin
      if ({1'b0, rom_idx} < cfg.rom_bytes) begin
        rsp.region = REGION_ROM;
        rsp.index  = rom_idx;
      end
    end else if (lo_save_hit) begin
      rsp.region = REGION_SAVE;
      rsp.index  = {7'd0, req.offset & sram_mask};
    end else if (sys_bank && ~upper) begin
      // low work RAM mirror, then I/O, then expansion (fault)
      if (req.offset[14:13] == 2'b00) begin
        rsp.region = REGION_WORK;
        rsp.index  = {7'd0, req.offset};
      end else if (req.offset[14:13] != 2'b11) begin
        rsp.region = REGION_IO;
        rsp.index  = {7'd0, req.offset};
      end
    end else if (wram_bank) begin
      rsp.region = REGION_WORK;
      rsp.index  = {6'd0, req.bank[0], req.offset};
    end
  end

endmodule

// ----- sim/tb_cartridge_bus_address_decoder.sv -----
// Self-checking testbench for the cartridge bus address decoder.
// Depends on cbad_pkg and the cartridge_bus_address_decoder RTL; needs no files.
// Decodes every beat with its own copy of the memory map and compares results.
module tb_cartridge_bus_address_decoder;
  import cbad_pkg::*;

  localparam logic       REQ_READ    = 1'b0;
  localparam logic       REQ_WRITE   = 1'b1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         PHASES       = 12;
  localparam int         PHASE_ITEMS  = 100;

  typedef struct packed {
    in_beat_t  access;
    out_beat_t decoded;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_ROM_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the map registers, updated on every write
  logic [1:0]  map_mode = ROM_MODE_RST;
  logic [23:0] map_rom_bytes = ROM_BYTES_RST;
  logic [4:0]  map_sram_log2 = SRAM_LOG2_RST;

  pending_t pending_q[$];
  int  mismatch_count = 0;
  bit  idle_on = 1'b1;

  cartridge_bus_address_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Expected region and index of one access under the current map
  function automatic out_beat_t decode_access(in_beat_t a);
    logic [23:0] addr;
    logic        upper;
    logic        sys_bank;
    logic        rom_hit;
    logic [22:0] rom_idx;
    logic [15:0] save_mask;
    out_beat_t   r;
    addr     = {a.bank, a.offset};
    upper    = a.offset[15];
    sys_bank = !a.bank[6];  // banks 00-3F and 80-BF
    rom_hit  = 1'b0;
    rom_idx  = '0;
    r.region = REGION_FAULT;
    r.index  = '0;
    if (a.req_type == REQ_READ) begin
      if (map_mode == MODE_LOROM) begin
        if ((a.bank <= 8'h7D || a.bank >= 8'h80) && upper) begin
          rom_hit = 1'b1;
          rom_idx = {1'b0, a.bank[6:0], a.offset[14:0]};
        end else if (a.bank >= 8'h70 && a.bank <= 8'h7D) begin
          save_mask = (map_sram_log2 >= 5'd16) ? 16'hFFFF
                                               : 16'hFFFF >> (16 - map_sram_log2);
          r.region = REGION_SAVE;
          r.index  = {7'd0, a.offset & save_mask};
          return r;
        end
      end else if (map_mode == MODE_HIROM || map_mode == MODE_EXHIROM) begin
        if ((sys_bank && upper) || (a.bank >= 8'h40 && a.bank <= 8'h7D) ||
            a.bank >= 8'hC0) begin
          rom_hit = 1'b1;
          rom_idx = {1'b0, addr[21:0]};
          if (map_mode == MODE_EXHIROM && !a.bank[7]) rom_idx[22] = 1'b1;
        end
      end
    end
    // ROM hits past the configured size fault
    if (rom_hit) begin
      if ({1'b0, rom_idx} < map_rom_bytes) begin
        r.region = REGION_ROM;
        r.index  = rom_idx;
      end
      return r;
    end
    // System area, work RAM banks, everything else faults
    if (sys_bank && !upper) begin
      if (a.offset < 16'h2000) begin
        r.region = REGION_WORK;
        r.index  = {7'd0, a.offset};
      end else if (a.offset < 16'h6000) begin
        r.region = REGION_IO;
        r.index  = {7'd0, a.offset};
      end
    end else if (a.bank == 8'h7E || a.bank == 8'h7F) begin
      r.region = REGION_WORK;
      r.index  = {6'd0, a.bank[0], a.offset};
    end
    return r;
  endfunction

  function automatic in_beat_t access(logic req, logic [7:0] bank, logic [15:0] offset);
    in_beat_t a;
    a.req_type = req;
    a.bank     = bank;
    a.offset   = offset;
    return a;
  endfunction

  // Random access, weighted toward the bank classes and offset boundaries
  function automatic in_beat_t rand_access();
    in_beat_t a;
    a.req_type = ($urandom_range(0, 3) == 0) ? REQ_WRITE : REQ_READ;
    case ($urandom_range(0, 5))
      0: a.bank = 8'($urandom);
      1: a.bank = {1'($urandom), 1'b0, 6'($urandom)};
      2: a.bank = 8'($urandom_range(8'h40, 8'h6F));
      3: a.bank = 8'($urandom_range(8'h70, 8'h7D));
      4: a.bank = 8'($urandom_range(8'h7E, 8'h7F));
      default: a.bank = 8'($urandom_range(8'hC0, 8'hFF));
    endcase
    case ($urandom_range(0, 4))
      0, 1: a.offset = 16'($urandom);
      2: begin
        case ($urandom_range(0, 7))
          0: a.offset = 16'h0000;
          1: a.offset = 16'h1FFF;
          2: a.offset = 16'h2000;
          3: a.offset = 16'h5FFF;
          4: a.offset = 16'h6000;
          5: a.offset = 16'h7FFF;
          6: a.offset = 16'h8000;
          default: a.offset = 16'hFFFF;
        endcase
      end
      3: a.offset = 16'($urandom_range(0, 16'h7FFF));
      default: a.offset = 16'($urandom_range(16'h8000, 16'hFFFF));
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Send one beat after a random gap (none while idling is off); the decode is predicted on acceptance
  task automatic send_access(in_beat_t a);
    int gap;
    pending_t p;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_beat  = a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p.access  = a;
    p.decoded = decode_access(a);
    pending_q.push_back(p);
  endtask

  // Drop valid and let every outstanding beat come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      CFG_ROM_MODE:  map_mode      = data[1:0];
      CFG_ROM_BYTES: map_rom_bytes = data[23:0];
      CFG_SRAM_LOG2: map_sram_log2 = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_map(logic [1:0] mode, logic [23:0] rom_bytes, logic [4:0] sram_log2);
    drain();
    write_reg(CFG_ROM_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_ROM_BYTES, rom_bytes);
    write_reg(CFG_SRAM_LOG2, CFG_DATA_W'(sram_log2));
  endtask

  // Every region and boundary under the reset map (low-ROM, 4 MiB, 8 KiB save RAM)
  task automatic test_reset_decode();
    send_access(access(REQ_READ,  8'h00, 16'h8000));
    send_access(access(REQ_READ,  8'hFF, 16'hFFFF));
    send_access(access(REQ_READ,  8'h70, 16'h1234));
    send_access(access(REQ_WRITE, 8'h70, 16'h1234));
    send_access(access(REQ_READ,  8'h00, 16'h0000));
    send_access(access(REQ_WRITE, 8'hBF, 16'h1FFF));
    send_access(access(REQ_READ,  8'h80, 16'h2000));
    send_access(access(REQ_WRITE, 8'h3F, 16'h5FFF));
    send_access(access(REQ_READ,  8'h00, 16'h6000));
    send_access(access(REQ_WRITE, 8'h00, 16'h7FFF));
    send_access(access(REQ_READ,  8'h7E, 16'h0000));
    send_access(access(REQ_WRITE, 8'h7F, 16'hFFFF));
    send_access(access(REQ_WRITE, 8'h80, 16'h8000));
    send_access(access(REQ_READ,  8'h40, 16'h0000));
  endtask

  // Extended high-ROM offset, ROM past its size, large and tiny save RAM, unused mode
  task automatic test_special_maps();
    set_map(MODE_EXHIROM, 24'h80_0000, 5'd16);
    send_access(access(REQ_READ, 8'h00, 16'h8000));
    send_access(access(REQ_READ, 8'hC0, 16'h0000));
    send_access(access(REQ_READ, 8'h7D, 16'hFFFF));
    set_map(MODE_HIROM, 24'h00_0000, 5'd0);
    send_access(access(REQ_READ, 8'h40, 16'h0000));
    send_access(access(REQ_READ, 8'h80, 16'h2000));
    set_map(MODE_LOROM, 24'h00_8000, 5'd16);
    send_access(access(REQ_READ, 8'h00, 16'hFFFF));
    send_access(access(REQ_READ, 8'h01, 16'h8000));
    send_access(access(REQ_READ, 8'h7D, 16'hFFFF));
    set_map(MODE_LOROM, 24'h80_0000, 5'd0);
    send_access(access(REQ_READ, 8'h70, 16'hFFFF));
    set_map(MODE_UNUSED, 24'h80_0000, 5'd13);
    send_access(access(REQ_READ, 8'h00, 16'h8000));
    send_access(access(REQ_READ, 8'h7E, 16'h1234));
    send_access(access(REQ_READ, 8'h00, 16'h0010));
  endtask

  // Random traffic over extreme and random maps; some phases run without idling
  task automatic test_random_maps();
    logic [23:0] rom_bytes;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_map(MODE_LOROM,   24'h80_0000, 5'd16);
        1: set_map(MODE_HIROM,   24'h00_0000, 5'd0);
        2: set_map(MODE_EXHIROM, 24'h80_0000, 5'd0);
        3: set_map(MODE_UNUSED,  24'h00_0001, 5'd16);
        default: begin
          case ($urandom_range(0, 3))
            0: rom_bytes = 24'h80_0000;
            1: rom_bytes = 24'h40_0000;
            2: rom_bytes = 24'($urandom_range(1, 24'h8000));
            default: rom_bytes = 24'($urandom_range(0, 24'h80_0000));
          endcase
          set_map(2'($urandom_range(0, 3)), rom_bytes, 5'($urandom_range(0, 16)));
        end
      endcase
      idle_on = (phase % 4) != 3;
      repeat (PHASE_ITEMS) send_access(rand_access());
    end
    idle_on = 1'b1;
  endtask

  // Result side: random stall per beat while idling is on, compare with the oldest expectation
  initial begin : result_checker
    int hold;
    pending_t want;
    wait (rst_n === 1'b1);
    forever begin
      hold = idle_on ? $urandom_range(0, 5) : 0;
      @(negedge clk);
      repeat (hold) begin
        out_stall = 1'b1;
        @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat region %0d index %h",
                                  out_beat.region, out_beat.index));
      end else begin
        want = pending_q.pop_front();
        if (out_beat.region !== want.decoded.region)
          report_mismatch($sformatf("%s %h:%h region got %0d want %0d",
                                    want.access.req_type ? "wr" : "rd",
                                    want.access.bank, want.access.offset,
                                    out_beat.region, want.decoded.region));
        if (out_beat.index !== want.decoded.index)
          report_mismatch($sformatf("%s %h:%h index got %h want %h",
                                    want.access.req_type ? "wr" : "rd",
                                    want.access.bank, want.access.offset,
                                    out_beat.index, want.decoded.index));
      end
    end
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #(8 * 400000);
    $display("cartridge_bus_address_decoder verification failed");
    $finish;
  end

  initial begin : main_sequence
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_reset_decode();
    test_special_maps();
    test_random_maps();
    drain();
    if (mismatch_count == 0) begin
      $display("cartridge_bus_address_decoder verification clean");
    end else begin
      $display("cartridge_bus_address_decoder verification failed");
    end
    $finish;
  end

endmodule
